// ===== hdl/array_doubly_linked_list_macros.svh =====
// ----------------------------------------------------------------------------
// array_doubly_linked_list_macros
// Assertion macros used by the checker of the linked-list block.
// ----------------------------------------------------------------------------
`ifndef ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH
`define ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADLL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adll assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADLL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adll assertion failed");

`endif

// ===== hdl/adll_pkg.sv =====
// ----------------------------------------------------------------------------
// adll_pkg
// Shared types and constants of the array-based doubly linked list.
// ----------------------------------------------------------------------------
package adll_pkg;

  localparam int ID_BITS          = 10;
  localparam int KIND_BITS        = 3;
  localparam int DEF_NODE_SLOTS   = 1024;
  localparam int DEF_VALUE_BITS   = 32;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_PUSH_HEAD  = 3'd0,
    KIND_PUSH_TAIL  = 3'd1,
    KIND_INS_AFTER  = 3'd2,
    KIND_INS_BEFORE = 3'd3,
    KIND_DELETE     = 3'd4,
    KIND_MOVE_HEAD  = 3'd5,
    KIND_MOVE_TAIL  = 3'd6,
    KIND_READ       = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_RD, ST_INS_A, ST_INS_B, ST_INB_A, ST_INB_B,
    ST_UNL_A, ST_UNL_B, ST_FRONT_A, ST_FRONT_B, ST_BACK_A, ST_BACK_B, ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_ACCEPT, CMD_READ, CMD_INS_A, CMD_INS_B, CMD_INB_A, CMD_INB_B,
    CMD_UNL_A, CMD_UNL_B, CMD_FRONT_A, CMD_FRONT_B, CMD_BACK_A, CMD_BACK_B,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  k_is_head;
    logic  k_is_tail;
    logic  head_zero;
    logic  tail_zero;
    logic  out_busy;
  } stat_t;

endpackage

// ===== hdl/adll_ctrl.sv =====
// ----------------------------------------------------------------------------
// adll_ctrl
// Sequencer that steps the datapath through the link updates of one item.
// ----------------------------------------------------------------------------
module adll_ctrl
  import adll_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  stat_t  stat,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = CMD_ACCEPT;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.full) begin
          state_nxt = ST_FINISH;
        end else begin
          case (stat.kind)
            KIND_PUSH_HEAD:  state_nxt = ST_FRONT_A;
            KIND_PUSH_TAIL:  state_nxt = ST_BACK_A;
            KIND_INS_AFTER:  state_nxt = stat.k_is_tail ? ST_BACK_A : ST_RD;
            KIND_INS_BEFORE: state_nxt = stat.k_is_head ? ST_FRONT_A : ST_RD;
            default:         state_nxt = ST_RD;
          endcase
        end
      end
      ST_RD: begin
        cmd = CMD_READ;
        case (stat.kind)
          KIND_INS_AFTER:  state_nxt = ST_INS_A;
          KIND_INS_BEFORE: state_nxt = ST_INB_A;
          KIND_READ:       state_nxt = ST_FINISH;
          default:         state_nxt = ST_UNL_A;
        endcase
      end
      ST_INS_A: begin
        cmd       = CMD_INS_A;
        state_nxt = ST_INS_B;
      end
      ST_INS_B: begin
        cmd       = CMD_INS_B;
        state_nxt = ST_FINISH;
      end
      ST_INB_A: begin
        cmd       = CMD_INB_A;
        state_nxt = ST_INB_B;
      end
      ST_INB_B: begin
        cmd       = CMD_INB_B;
        state_nxt = ST_FINISH;
      end
      ST_UNL_A: begin
        cmd       = CMD_UNL_A;
        state_nxt = ST_UNL_B;
      end
      ST_UNL_B: begin
        cmd = CMD_UNL_B;
        case (stat.kind)
          KIND_MOVE_HEAD: state_nxt = ST_FRONT_A;
          KIND_MOVE_TAIL: state_nxt = ST_BACK_A;
          default:        state_nxt = ST_FINISH;
        endcase
      end
      ST_FRONT_A: begin
        cmd       = CMD_FRONT_A;
        state_nxt = stat.head_zero ? ST_FINISH : ST_FRONT_B;
      end
      ST_FRONT_B: begin
        cmd       = CMD_FRONT_B;
        state_nxt = ST_FINISH;
      end
      ST_BACK_A: begin
        cmd       = CMD_BACK_A;
        state_nxt = stat.tail_zero ? ST_FINISH : ST_BACK_B;
      end
      ST_BACK_B: begin
        cmd       = CMD_BACK_B;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd       = CMD_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/adll_dpath.sv =====
// ----------------------------------------------------------------------------
// adll_dpath
// Link, value memories, head/tail/id registers and the result register.
// ----------------------------------------------------------------------------
module adll_dpath
  import adll_pkg::*;
#(
  parameter int NODE_SLOTS = DEF_NODE_SLOTS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [KIND_BITS-1:0]  in_kind,
  input  logic [ID_BITS-1:0]    in_node,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_BITS-1:0]    out_alloc_id,
  output logic [ID_BITS-1:0]    out_list_head,
  output logic [ID_BITS-1:0]    out_list_tail,
  output logic [VALUE_BITS-1:0] out_read_value,
  output logic [ID_BITS-1:0]    out_read_left,
  output logic [ID_BITS-1:0]    out_read_right,
  output logic                  out_full_res
);

  localparam int IW = $clog2(NODE_SLOTS);

  logic [IW-1:0]         left_mem  [NODE_SLOTS];
  logic [IW-1:0]         right_mem [NODE_SLOTS];
  logic [VALUE_BITS-1:0] value_mem [NODE_SLOTS];

  kind_t                 kind_r;
  logic [IW-1:0]         k_r, n_r, head_r, tail_r, last_r;
  logic                  full_r;
  logic [IW-1:0]         lq_r, rq_r;
  logic [VALUE_BITS-1:0] vq_r;

  logic                  out_valid_r;
  logic [ID_BITS-1:0]    alloc_id_r, head_out_r, tail_out_r, rl_r, rr_r;
  logic [VALUE_BITS-1:0] rv_r;
  logic                  full_out_r;

  logic [31:0]   rem;
  logic [IW-1:0] k_in;
  logic          is_ins, in_is_ins, no_ids;
  logic [IW-1:0] x;
  logic          l_we, r_we;
  logic [IW-1:0] l_wa, l_wd, r_wa, r_wd;

  // Node operand reduced modulo the slot count by restoring subtraction.
  always_comb begin
    rem = 32'(in_node);
    for (int j = ID_BITS - 1; j >= 0; j--) begin
      if (rem >= (32'(NODE_SLOTS) << j)) begin
        rem = rem - (32'(NODE_SLOTS) << j);
      end
    end
    k_in = IW'(rem);
  end

  assign in_is_ins = (in_kind <= KIND_BITS'(KIND_INS_BEFORE));
  assign no_ids    = (last_r >= IW'(NODE_SLOTS - 1));
  assign is_ins    = kind_r inside {KIND_PUSH_HEAD, KIND_PUSH_TAIL,
                                    KIND_INS_AFTER, KIND_INS_BEFORE};
  assign x         = is_ins ? n_r : k_r;

  always_comb begin
    l_we = 1'b0;  l_wa = '0;  l_wd = '0;
    r_we = 1'b0;  r_wa = '0;  r_wd = '0;
    case (cmd)
      CMD_INS_A: begin
        r_we = 1'b1;  r_wa = k_r;  r_wd = n_r;
        l_we = 1'b1;  l_wa = n_r;  l_wd = k_r;
      end
      CMD_INS_B: begin
        r_we = 1'b1;  r_wa = n_r;  r_wd = rq_r;
        l_we = 1'b1;  l_wa = rq_r; l_wd = n_r;
      end
      CMD_INB_A: begin
        l_we = 1'b1;  l_wa = k_r;  l_wd = n_r;
        r_we = 1'b1;  r_wa = n_r;  r_wd = k_r;
      end
      CMD_INB_B: begin
        l_we = 1'b1;  l_wa = n_r;  l_wd = lq_r;
        r_we = 1'b1;  r_wa = lq_r; r_wd = n_r;
      end
      CMD_UNL_A: begin
        r_we = (lq_r != '0);  r_wa = lq_r;  r_wd = rq_r;
        l_we = (rq_r != '0);  l_wa = rq_r;  l_wd = lq_r;
      end
      CMD_UNL_B: begin
        l_we = 1'b1;  l_wa = k_r;
        r_we = 1'b1;  r_wa = k_r;
      end
      CMD_FRONT_A: begin
        if (head_r == '0) begin
          l_we = 1'b1;  l_wa = x;
          r_we = 1'b1;  r_wa = x;
        end else begin
          l_we = 1'b1;  l_wa = head_r;  l_wd = x;
          r_we = 1'b1;  r_wa = x;       r_wd = head_r;
        end
      end
      CMD_FRONT_B: begin
        l_we = 1'b1;  l_wa = x;
      end
      CMD_BACK_A: begin
        if (tail_r == '0) begin
          l_we = 1'b1;  l_wa = x;
          r_we = 1'b1;  r_wa = x;
        end else begin
          r_we = 1'b1;  r_wa = tail_r;  r_wd = x;
          l_we = 1'b1;  l_wa = x;       l_wd = tail_r;
        end
      end
      CMD_BACK_B: begin
        r_we = 1'b1;  r_wa = x;
      end
      default: begin
      end
    endcase
  end

  // Memories: one write per array per cycle, registered reads.
  always_ff @(posedge clk) begin
    if (l_we) begin
      left_mem[l_wa] <= l_wd;
    end
    if (r_we) begin
      right_mem[r_wa] <= r_wd;
    end
    if (cmd == CMD_ACCEPT && in_is_ins && !no_ids) begin
      value_mem[last_r + IW'(1)] <= in_value;
    end
    if (cmd == CMD_READ) begin
      lq_r <= left_mem[k_r];
      rq_r <= right_mem[k_r];
      vq_r <= value_mem[k_r];
    end
  end

  // Item operands.
  always_ff @(posedge clk) begin
    if (cmd == CMD_ACCEPT) begin
      kind_r <= kind_t'(in_kind);
      k_r    <= k_in;
      n_r    <= (in_is_ins && !no_ids) ? last_r + IW'(1) : '0;
    end
  end

  // List registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      last_r <= '0;
      full_r <= 1'b0;
    end else begin
      case (cmd)
        CMD_ACCEPT: begin
          full_r <= in_is_ins && no_ids;
          if (in_is_ins && !no_ids) begin
            last_r <= last_r + IW'(1);
          end
        end
        CMD_UNL_A: begin
          if (lq_r == '0) begin
            head_r <= rq_r;
          end
          if (rq_r == '0) begin
            tail_r <= lq_r;
          end
        end
        CMD_FRONT_A: begin
          head_r <= x;
          if (head_r == '0) begin
            tail_r <= x;
          end
        end
        CMD_BACK_A: begin
          tail_r <= x;
          if (tail_r == '0) begin
            head_r <= x;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == CMD_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_FINISH) begin
      alloc_id_r <= ID_BITS'(n_r);
      head_out_r <= ID_BITS'(head_r);
      tail_out_r <= ID_BITS'(tail_r);
      full_out_r <= full_r;
      if (kind_r == KIND_READ) begin
        rv_r <= vq_r;
        rl_r <= ID_BITS'(lq_r);
        rr_r <= ID_BITS'(rq_r);
      end else begin
        rv_r <= '0;
        rl_r <= '0;
        rr_r <= '0;
      end
    end
  end

  assign stat.kind      = kind_r;
  assign stat.full      = full_r;
  assign stat.k_is_head = (k_r == head_r);
  assign stat.k_is_tail = (k_r == tail_r);
  assign stat.head_zero = (head_r == '0);
  assign stat.tail_zero = (tail_r == '0);
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_alloc_id   = alloc_id_r;
  assign out_list_head  = head_out_r;
  assign out_list_tail  = tail_out_r;
  assign out_read_value = rv_r;
  assign out_read_left  = rl_r;
  assign out_read_right = rr_r;
  assign out_full_res   = full_out_r;

endmodule

// ===== hdl/array_doubly_linked_list.sv =====
// ----------------------------------------------------------------------------
// array_doubly_linked_list
// Doubly linked list kept in left-link, right-link and value memories.
// ----------------------------------------------------------------------------
// Each input beat carries one list operation (push head, push tail, insert
// after or before a node, delete, move to head or tail, read) and produces
// exactly one result beat with the allocated node id, the head and tail after
// the operation, the read fields and the full flag. Node ids start at 1 and
// are never reused; id 0 is the null link. Operations are handled one at a
// time by a sequencer, because every link memory takes one write per cycle:
// after acceptance the sequencer decodes the item, reads the node's links
// where the kind needs them, rewrites the links one write per memory per
// step and loads the result register; a dropped insert goes from decode
// straight to the load. A waiting result holds the sequencer until the
// output register is free. The next item is accepted as soon as the
// sequencer is back in idle, even while the last result still waits in
// the output register. Node operands are trusted to name live nodes; a
// read of a never-written entry returns undefined data.
// ----------------------------------------------------------------------------
module array_doubly_linked_list
  import adll_pkg::*;
#(
  parameter int NODE_SLOTS = DEF_NODE_SLOTS,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  localparam int IN_W  = ((ID_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((5 * ID_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // node, value (from bit 0 up), zero padding
  input  logic [IN_W-1:0]      in_tdata,
  // kind
  input  logic [KIND_BITS-1:0] in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // allocated id, list_head, list_tail, read_value, read_left, read_right
  output logic [OUT_W-1:0]     out_tdata,
  // full_res
  output logic [0:0]           out_tuser
);

  localparam int OUT_USED = 5 * ID_BITS + VALUE_BITS;

  cmd_t  cmd;
  stat_t stat;

  logic [ID_BITS-1:0]    alloc_id, list_head, list_tail, read_left, read_right;
  logic [VALUE_BITS-1:0] read_value;
  logic                  full_res;

  adll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  adll_dpath #(
    .NODE_SLOTS (NODE_SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_tuser),
    .in_node        (in_tdata[ID_BITS-1:0]),
    .in_value       (in_tdata[ID_BITS +: VALUE_BITS]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_alloc_id   (alloc_id),
    .out_list_head  (list_head),
    .out_list_tail  (list_tail),
    .out_read_value (read_value),
    .out_read_left  (read_left),
    .out_read_right (read_right),
    .out_full_res   (full_res)
  );

  // Result beat packing, first field in the low bits.
  assign out_tdata = OUT_W'({read_right, read_left, read_value,
                             list_tail, list_head, alloc_id});
  assign out_tuser = full_res;

  // The padding above OUT_USED is always zero.
  if (OUT_W < OUT_USED) begin : g_bad_width
    $error("output packing width too small");
  end

endmodule

// ===== hdl/adll_checker.sv =====
// ----------------------------------------------------------------------------
// adll_checker
// Port-level checks of the linked-list block, bound to the top level.
// ----------------------------------------------------------------------------
`include "array_doubly_linked_list_macros.svh"

module adll_checker
  import adll_pkg::*;
#(
  parameter int OUT_W = 88
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [0:0]       out_tuser
);

  // Items are handled one at a time, so acceptance closes the input.
  `ADLL_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

  // A dropped insert never reports a node id.
  `ADLL_ASSERT_NOW(a_full_no_id, out_tvalid && out_tuser[0], out_tdata[ID_BITS-1:0] == '0)

  // A stalled result holds.
  `ADLL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind array_doubly_linked_list adll_checker #(
  .OUT_W (OUT_W)
) u_adll_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/sv/array_doubly_linked_list_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_doubly_linked_list_tb
// Self-checking bench for the array-based doubly linked list.
// ----------------------------------------------------------------------------
// A queue of list operations is filled up front and fed to the block by a
// clocked driver. A shadow copy of the link and value memories predicts the
// result of every accepted beat. A clocked monitor compares each result beat
// field by field with the oldest prediction. Operands that name a node are
// picked from the ids that are live in the generator-side mirror, so no entry that was never
// written is ever read. Ids run out partway through the random part, so the
// full case and list draining are both covered.
// ----------------------------------------------------------------------------
module array_doubly_linked_list_tb;
  import adll_pkg::*;

  localparam int SLOTS = DEF_NODE_SLOTS;
  localparam int IN_W  = ((ID_BITS + DEF_VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((5 * ID_BITS + DEF_VALUE_BITS + 7) / 8) * 8;

  typedef struct packed {
    kind_t             kind;
    logic [ID_BITS-1:0] node;
    logic [31:0]        value;
  } list_op_t;

  typedef struct packed {
    logic [ID_BITS-1:0] alloc_id;
    logic [ID_BITS-1:0] head;
    logic [ID_BITS-1:0] tail;
    logic [31:0]        rd_value;
    logic [ID_BITS-1:0] rd_left;
    logic [ID_BITS-1:0] rd_right;
    logic               full;
  } list_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [KIND_BITS-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [0:0] out_tuser;

  array_doubly_linked_list DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow state of the block.
  logic [ID_BITS-1:0] sh_left [SLOTS];
  logic [ID_BITS-1:0] sh_right[SLOTS];
  logic [31:0]        sh_value[SLOTS];
  logic [ID_BITS-1:0] sh_head, sh_tail, sh_last;

  list_op_t  pending_ops[$];
  list_res_t expected_res[$];
  int  errors = 0;
  bit  stim_done = 1'b0;
  bit  idle_off = 1'b0;
  bit  long_hold = 1'b0;

  // Generator-side mirror used only to pick live operands.
  logic [ID_BITS-1:0] live_ids[$];
  int  gen_last = 0;

  function automatic void link_front(logic [ID_BITS-1:0] n);
    if (sh_head == 0) begin
      sh_head = n; sh_tail = n; sh_left[n] = 0; sh_right[n] = 0;
    end else begin
      sh_left[sh_head] = n; sh_left[n] = 0; sh_right[n] = sh_head; sh_head = n;
    end
  endfunction

  function automatic void link_back(logic [ID_BITS-1:0] n);
    if (sh_tail == 0) begin
      sh_head = n; sh_tail = n; sh_left[n] = 0; sh_right[n] = 0;
    end else begin
      sh_right[sh_tail] = n; sh_right[n] = 0; sh_left[n] = sh_tail; sh_tail = n;
    end
  endfunction

  function automatic void unlink(logic [ID_BITS-1:0] k);
    logic [ID_BITS-1:0] p, x;
    p = sh_left[k];
    x = sh_right[k];
    if (p != 0) sh_right[p] = x; else sh_head = x;
    if (x != 0) sh_left[x] = p; else sh_tail = p;
    sh_left[k] = 0;
    sh_right[k] = 0;
  endfunction

  // Applies one operation to the shadow list and returns the predicted beat.
  function automatic list_res_t apply_op(list_op_t op);
    list_res_t r;
    logic [ID_BITS-1:0] k, n, nb;
    r = '0;
    k = op.node;
    case (op.kind)
      KIND_PUSH_HEAD, KIND_PUSH_TAIL, KIND_INS_AFTER, KIND_INS_BEFORE: begin
        if (sh_last >= SLOTS - 1) begin
          r.full = 1'b1;
        end else begin
          sh_last = sh_last + 1;
          n = sh_last;
          r.alloc_id = n;
          sh_value[n] = op.value;
          if (op.kind == KIND_PUSH_HEAD) link_front(n);
          else if (op.kind == KIND_PUSH_TAIL) link_back(n);
          else if (op.kind == KIND_INS_AFTER) begin
            if (k == sh_tail) link_back(n);
            else begin
              nb = sh_right[k];
              sh_right[k] = n; sh_left[n] = k; sh_right[n] = nb; sh_left[nb] = n;
            end
          end else begin
            if (k == sh_head) link_front(n);
            else begin
              nb = sh_left[k];
              sh_left[k] = n; sh_right[n] = k; sh_left[n] = nb; sh_right[nb] = n;
            end
          end
        end
      end
      KIND_DELETE: unlink(k);
      KIND_MOVE_HEAD: begin unlink(k); link_front(k); end
      KIND_MOVE_TAIL: begin unlink(k); link_back(k); end
      default: begin
        r.rd_value = sh_value[k];
        r.rd_left  = sh_left[k];
        r.rd_right = sh_right[k];
      end
    endcase
    r.head = sh_head;
    r.tail = sh_tail;
    return r;
  endfunction

  // Queues one operation; node operands of kinds 2 to 7 come from live ids.
  task automatic queue_op(kind_t kd, logic [31:0] val);
    list_op_t op;
    int idx;
    op.kind = kd;
    op.value = val;
    op.node = ID_BITS'($urandom);
    if (kd >= KIND_INS_AFTER) begin
      idx = $urandom_range(live_ids.size() - 1);
      op.node = live_ids[idx];
      if (kd == KIND_DELETE) live_ids.delete(idx);
    end
    if (kd <= KIND_INS_BEFORE && gen_last < SLOTS - 1) begin
      gen_last++;
      live_ids.push_back(ID_BITS'(gen_last));
    end
    pending_ops.push_back(op);
  endtask

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (live_ids.size() == 0) return (r < 50) ? KIND_PUSH_HEAD : KIND_PUSH_TAIL;
    // Mostly inserts while ids remain, so they run out; then mostly deletes.
    if (gen_last < SLOTS - 1 && r < 70) return kind_t'($urandom_range(3));
    if (r < 60) return KIND_DELETE;
    return kind_t'($urandom_range(7, 2));
  endfunction

  // Driver: holds a beat until it is accepted, bursts of idle in between.
  int drv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          list_op_t op;
          op = pending_ops.pop_front();
          expected_res.push_back(apply_op(op));
          in_tvalid <= 1'b1;
          in_tuser  <= op.kind;
          in_tdata  <= {{(IN_W-ID_BITS-32){1'b0}}, op.value, op.node};
          if (!idle_off && $urandom_range(9) == 0) drv_gap <= $urandom_range(19, 1);
        end else begin
          in_tvalid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // Receiver readiness: random stalls, one long hold-off, none at the end.
  int rcv_gap = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (long_hold && hold_cnt < 300) begin
      hold_cnt <= hold_cnt + 1;
      out_tready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap <= rcv_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!idle_off && $urandom_range(9) == 0) rcv_gap <= $urandom_range(19, 1);
    end
  end

  // Monitor: compares each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      list_res_t got, exp_r;
      got = '{alloc_id: out_tdata[9:0], head: out_tdata[19:10], tail: out_tdata[29:20],
              rd_value: out_tdata[61:30], rd_left: out_tdata[71:62],
              rd_right: out_tdata[81:72], full: out_tuser[0]};
      if (expected_res.size() == 0) begin
        $display("%0t: result beat expected none, actual %p", $time, got);
        errors++;
      end else begin
        exp_r = expected_res.pop_front();
        if (got.alloc_id != exp_r.alloc_id)
          $display("%0t: allocated id expected %0d actual %0d", $time, exp_r.alloc_id,
                   got.alloc_id);
        if (got.head != exp_r.head)
          $display("%0t: list_head expected %0d actual %0d", $time, exp_r.head, got.head);
        if (got.tail != exp_r.tail)
          $display("%0t: list_tail expected %0d actual %0d", $time, exp_r.tail, got.tail);
        if (got.rd_value !== exp_r.rd_value)
          $display("%0t: read_value expected %h actual %h", $time, exp_r.rd_value,
                   got.rd_value);
        if (got.rd_left != exp_r.rd_left)
          $display("%0t: read_left expected %0d actual %0d", $time, exp_r.rd_left, got.rd_left);
        if (got.rd_right != exp_r.rd_right)
          $display("%0t: read_right expected %0d actual %0d", $time, exp_r.rd_right,
                   got.rd_right);
        if (got.full != exp_r.full)
          $display("%0t: full_res expected %0d actual %0d", $time, exp_r.full, got.full);
        if (got !== exp_r) errors++;
      end
    end
  end

  initial begin
    sh_head = 0; sh_tail = 0; sh_last = 0;
    // Directed: empty-list pushes, every kind, head and tail operands.
    queue_op(KIND_PUSH_TAIL, 32'h7FFF_FFFF);
    queue_op(KIND_READ, 0);
    queue_op(KIND_DELETE, 0);               // list becomes empty
    queue_op(KIND_PUSH_HEAD, 32'h8000_0000);
    queue_op(KIND_PUSH_HEAD, 32'hFFFF_FFFF);
    queue_op(KIND_PUSH_TAIL, 32'h0000_0000);
    queue_op(KIND_INS_AFTER, 32'h5555_5555);
    queue_op(KIND_INS_BEFORE, 32'hAAAA_AAAA);
    queue_op(KIND_MOVE_HEAD, 0);
    queue_op(KIND_MOVE_TAIL, 0);
    repeat (6) queue_op(KIND_READ, 0);
    queue_op(KIND_DELETE, 0);
    queue_op(KIND_MOVE_TAIL, 0);
    queue_op(KIND_READ, 0);
    for (int i = 0; i < 1500; i++) queue_op(pick_kind(), $urandom);
    // Ids are gone by now: more inserts are dropped and flagged full.
    repeat (4) queue_op(kind_t'($urandom_range(3)), $urandom);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (200) @(posedge clk);
    long_hold <= 1'b1;
    wait (pending_ops.size() < 60);
    idle_off <= 1'b1;
    wait (stim_done && expected_res.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("array_doubly_linked_list_tb passed");
    end else begin
      $display("array_doubly_linked_list_tb failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("array_doubly_linked_list_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/adll_pkg.sv
hdl/adll_ctrl.sv
hdl/adll_dpath.sv
hdl/array_doubly_linked_list.sv
hdl/adll_checker.sv
tb/sv/array_doubly_linked_list_tb.sv
